// ===== hw/rtl/fxa_pkg.sv =====
`default_nettype none
package fxa_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 8;
  localparam int FLT_BIAS      = 127;
  localparam int FLT_MANT      = 23;

  // pipeline depths of the units, counted from the input register
  localparam int ARITH_LAT = 2;
  localparam int CVT_LAT   = 4;
  localparam int DIV_LAT   = DATA_W + 2;

  typedef enum logic [3:0] {
    MODE_ADD        = 4'd0,
    MODE_SUB        = 4'd1,
    MODE_MUL        = 4'd2,
    MODE_DIV        = 4'd3,
    MODE_COMPARE    = 4'd4,
    MODE_FROM_INT   = 4'd5,
    MODE_TO_INT     = 4'd6,
    MODE_FROM_FLOAT = 4'd7,
    MODE_TO_FLOAT   = 4'd8,
    MODE_MAX        = 4'd9,
    MODE_MIN        = 4'd10
  } mode_t;

  typedef struct packed {
    logic less;
    logic greater;
    logic equal;
  } cmp_flags_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fxa_arith.sv =====
`default_nettype none
module fxa_arith
  import fxa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic [3:0]        mode,
  input  wire logic [DATA_W-1:0] a,
  input  wire logic [DATA_W-1:0] b,
  output logic      [DATA_W-1:0] res,
  output cmp_flags_t             flags
);

  logic [3:0]        mode1;
  logic [DATA_W-1:0] prod;
  logic              sdiff;
  logic [DATA_W-1:0] r1;
  cmp_flags_t        f1;
  logic [DATA_W-1:0] simple;
  cmp_flags_t        f_next;
  logic              lt;
  logic [DATA_W-1:0] shr;
  logic [DATA_W-1:0] mul_r;

  assign lt = $signed(a) < $signed(b);

  // combinational ops and compare flags
  always_comb begin
    simple = '0;
    f_next = '0;
    unique case (mode)
      MODE_ADD:      simple = a + b;
      MODE_SUB:      simple = a - b;
      MODE_COMPARE: begin
        f_next.less    = lt;
        f_next.greater = $signed(b) < $signed(a);
        f_next.equal   = (a == b);
      end
      MODE_FROM_INT: simple = a << FRAC_BITS;
      MODE_TO_INT:   simple = DATA_W'($signed(a) >>> FRAC_BITS);
      MODE_MAX:      simple = ($signed(b) < $signed(a)) ? a : b;
      MODE_MIN:      simple = lt ? a : b;
      default:       simple = '0;
    endcase
  end

  // stage 1: low product word and the simple results
  always_ff @(posedge clk) begin
    mode1 <= mode;
    prod  <= a * b;
    sdiff <= a[DATA_W-1] ^ b[DATA_W-1];
    r1    <= simple;
    f1    <= f_next;
  end

  // product scaling: mixed signs shift arithmetically and force non-positive
  always_comb begin
    shr = DATA_W'($signed(prod) >>> FRAC_BITS);
    if (sdiff) begin
      mul_r = (shr != '0 && !shr[DATA_W-1]) ? (~shr + 1'b1) : shr;
    end else begin
      mul_r = prod >> FRAC_BITS;
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    res   <= (mode1 == MODE_MUL) ? mul_r : r1;
    flags <= f1;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fxa_cvt.sv =====
`default_nettype none
module fxa_cvt
  import fxa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic [3:0]        mode,
  input  wire logic [DATA_W-1:0] a,
  output logic      [DATA_W-1:0] res
);

  localparam int PW = $clog2(DATA_W) + 1;

  // float to fixed signals
  logic signed [9:0] s_comb;
  logic signed [9:0] sm1;
  logic signed [9:0] neg_s;
  logic [DATA_W-1:0] rnd;
  logic [DATA_W-1:0] ff_sh_next;
  logic signed [9:0] ff_s1;
  logic [DATA_W-1:0] ff_v1;
  logic              ff_zero1, ff_zero2;
  logic              ff_sign1, ff_sign2;
  logic [DATA_W-1:0] ff_sh2;
  logic [DATA_W-1:0] ff_r3;

  // fixed to float signals
  logic [DATA_W-1:0] tf_mag1, tf_mag2;
  logic              tf_sign1, tf_sign2, tf_sign3;
  logic              tf_zero1, tf_zero2, tf_zero3;
  logic [PW-1:0]     p_next;
  logic [PW-1:0]     tf_p2, tf_p3;
  logic [DATA_W-1:0] norm;
  logic [FLT_MANT:0] keep3;
  logic              guard3, sticky3;
  logic              inc;
  logic [FLT_MANT+1:0] k2;
  logic [FLT_MANT-1:0] mant;
  logic [PW-1:0]     p_fin;
  logic [7:0]        expo;

  logic [3:0] mode1, mode2, mode3;

  // shift count relative to the mantissa and the half-up rounding addend
  always_comb begin
    s_comb = $signed(10'(FLT_MANT + FLT_BIAS - FRAC_BITS))
           - $signed({2'b00, a[30:23]});
    sm1 = s_comb - 10'sd1;
    rnd = (s_comb >= 10'sd1 && s_comb <= 10'sd32) ? (DATA_W'(1) << sm1[4:0]) : '0;
  end

  // stage 1
  always_ff @(posedge clk) begin
    mode1    <= mode;
    ff_s1    <= s_comb;
    ff_v1    <= {8'b0, 1'b1, a[FLT_MANT-1:0]} + rnd;
    ff_zero1 <= (a[30:0] == '0);
    ff_sign1 <= a[DATA_W-1];
    tf_mag1  <= a[DATA_W-1] ? (~a + 1'b1) : a;
    tf_sign1 <= a[DATA_W-1];
    tf_zero1 <= (a == '0);
  end

  // float to fixed alignment; MSB search for fixed to float
  always_comb begin
    neg_s = -ff_s1;
    if (ff_s1 < 10'sd0) begin
      ff_sh_next = (ff_s1 <= -10'sd32) ? '0 : (ff_v1 << neg_s[4:0]);
    end else begin
      ff_sh_next = (ff_s1 >= 10'sd32) ? '0 : (ff_v1 >> ff_s1[4:0]);
    end
    p_next = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (tf_mag1[i]) p_next = PW'(i);
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    mode2    <= mode1;
    ff_sh2   <= ff_sh_next;
    ff_zero2 <= ff_zero1;
    ff_sign2 <= ff_sign1;
    tf_mag2  <= tf_mag1;
    tf_p2    <= p_next;
    tf_sign2 <= tf_sign1;
    tf_zero2 <= tf_zero1;
  end

  // normalize so the leading one sits at the top bit
  assign norm = tf_mag2 << (PW'(DATA_W - 1) - tf_p2);

  // stage 3
  always_ff @(posedge clk) begin
    mode3    <= mode2;
    ff_r3    <= ff_zero2 ? '0 : (ff_sign2 ? (~ff_sh2 + 1'b1) : ff_sh2);
    keep3    <= norm[DATA_W-1:DATA_W-FLT_MANT-1];
    guard3   <= norm[DATA_W-FLT_MANT-2];
    sticky3  <= |norm[DATA_W-FLT_MANT-3:0];
    tf_p3    <= tf_p2;
    tf_sign3 <= tf_sign2;
    tf_zero3 <= tf_zero2;
  end

  // round to nearest even, carry into the exponent on mantissa overflow
  always_comb begin
    inc = guard3 & (sticky3 | keep3[0]);
    k2  = {1'b0, keep3} + (FLT_MANT+2)'(inc);
    if (k2[FLT_MANT+1]) begin
      mant  = '0;
      p_fin = tf_p3 + 1'b1;
    end else begin
      mant  = k2[FLT_MANT-1:0];
      p_fin = tf_p3;
    end
    expo = 8'(FLT_BIAS - FRAC_BITS) + 8'(p_fin);
  end

  // stage 4: select by mode
  always_ff @(posedge clk) begin
    if (mode3 == MODE_FROM_FLOAT) begin
      res <= ff_r3;
    end else if (mode3 == MODE_TO_FLOAT && !tf_zero3) begin
      res <= {tf_sign3, expo, mant};
    end else begin
      res <= '0;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fxa_div.sv =====
`default_nettype none
module fxa_div
  import fxa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [3:0]        mode,
  input  wire logic [DATA_W-1:0] a,
  input  wire logic [DATA_W-1:0] b,
  output logic                   out_valid,
  output logic      [DATA_W-1:0] q,
  output logic                   dz
);

  // one quotient bit per stage, restoring division on magnitudes
  logic [DATA_W-1:0] rem   [0:DATA_W];
  logic [DATA_W-1:0] dq    [0:DATA_W];
  logic [DATA_W-1:0] mb    [0:DATA_W];
  logic              neg   [0:DATA_W];
  logic              isdiv [0:DATA_W];
  logic              zdiv  [0:DATA_W];
  logic              vld   [0:DATA_W];
  logic [DATA_W-1:0] n;

  assign n = a << FRAC_BITS;

  // prep stage: signs and magnitudes
  always_ff @(posedge clk) begin
    rem[0]   <= '0;
    dq[0]    <= n[DATA_W-1] ? (~n + 1'b1) : n;
    mb[0]    <= b[DATA_W-1] ? (~b + 1'b1) : b;
    neg[0]   <= n[DATA_W-1] ^ b[DATA_W-1];
    isdiv[0] <= (mode == MODE_DIV);
    zdiv[0]  <= (b == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  for (genvar k = 0; k < DATA_W; k++) begin : g_stage
    logic [DATA_W:0] sh;
    logic            ge;

    assign sh = {rem[k], dq[k][DATA_W-1]};
    assign ge = (sh >= {1'b0, mb[k]});

    always_ff @(posedge clk) begin
      rem[k+1]   <= ge ? DATA_W'(sh - {1'b0, mb[k]}) : sh[DATA_W-1:0];
      dq[k+1]    <= {dq[k][DATA_W-2:0], ge};
      mb[k+1]    <= mb[k];
      neg[k+1]   <= neg[k];
      isdiv[k+1] <= isdiv[k];
      zdiv[k+1]  <= zdiv[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end
  end

  // final stage: sign fix, zero outside divide mode or on zero divisor
  always_ff @(posedge clk) begin
    if (isdiv[DATA_W] && !zdiv[DATA_W]) begin
      q <= neg[DATA_W] ? (~dq[DATA_W] + 1'b1) : dq[DATA_W];
    end else begin
      q <= '0;
    end
    dz <= isdiv[DATA_W] & zdiv[DATA_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[DATA_W];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fixed_point_q24_8_alu_top.sv =====
// A request passes the input register, the unit pipelines and the output register before done rises.
// Throughput: one request per cycle; the depth is set by the divider, one quotient bit a stage.
// All other units are padded with delay registers to the same depth, so results stay in order.
// busy is always low: the pipeline never stalls and the receiver takes every result.
// Reset (rst, synchronous) clears the valid bits; requests in flight are dropped.
`default_nettype none
module fixed_point_q24_8_alu_top
  import fxa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [3:0]         mode,
  input  wire logic signed [31:0] operand_a,
  input  wire logic signed [31:0] operand_b,
  output logic                    done,
  output logic signed [31:0]      result,
  output logic                    less,
  output logic                    greater,
  output logic                    equal,
  output logic                    divide_by_zero
);

  localparam int AR_DLY    = DIV_LAT - ARITH_LAT;
  localparam int CV_DLY    = DIV_LAT - CVT_LAT;
  localparam int TOTAL_LAT = DIV_LAT + 2;

  logic              v1;
  logic [3:0]        mode1;
  logic [DATA_W-1:0] a1, b1;
  logic [DATA_W-1:0] ar_res;
  cmp_flags_t        ar_flags;
  logic [DATA_W-1:0] cv_res;
  logic              div_valid;
  logic [DATA_W-1:0] div_q;
  logic              div_dz;
  logic [DATA_W-1:0] ar_pipe [0:AR_DLY-1];
  cmp_flags_t        fl_pipe [0:AR_DLY-1];
  logic [DATA_W-1:0] cv_pipe [0:CV_DLY-1];

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    mode1 <= mode;
    a1    <= operand_a;
    b1    <= operand_b;
  end

  fxa_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
    .clk   (clk),
    .mode  (mode1),
    .a     (a1),
    .b     (b1),
    .res   (ar_res),
    .flags (ar_flags)
  );

  fxa_cvt #(.FRAC_BITS(FRAC_BITS)) u_cvt (
    .clk  (clk),
    .mode (mode1),
    .a    (a1),
    .res  (cv_res)
  );

  fxa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .mode      (mode1),
    .a         (a1),
    .b         (b1),
    .out_valid (div_valid),
    .q         (div_q),
    .dz        (div_dz)
  );

  // align the short units with the divider
  always_ff @(posedge clk) begin
    ar_pipe[0] <= ar_res;
    fl_pipe[0] <= ar_flags;
    cv_pipe[0] <= cv_res;
    for (int i = 1; i < AR_DLY; i++) begin
      ar_pipe[i] <= ar_pipe[i-1];
      fl_pipe[i] <= fl_pipe[i-1];
    end
    for (int i = 1; i < CV_DLY; i++) begin
      cv_pipe[i] <= cv_pipe[i-1];
    end
  end

  // output register; units not addressed by the mode drive zero
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    result         <= div_q | ar_pipe[AR_DLY-1] | cv_pipe[CV_DLY-1];
    less           <= fl_pipe[AR_DLY-1].less;
    greater        <= fl_pipe[AR_DLY-1].greater;
    equal          <= fl_pipe[AR_DLY-1].equal;
    divide_by_zero <= div_dz;
  end

  // every result traces back to a request taken a fixed depth earlier
  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOTAL_LAT))
    else $error("done without a matching request");

  // flags are only meaningful while done is high
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot0({less, greater, equal, divide_by_zero}))
    else $error("more than one status flag set");

  a_flag_zero_res: assert property (@(posedge clk) disable iff (rst)
    (done && (less || greater || equal || divide_by_zero)) |-> (result == '0))
    else $error("flagged result is not zero");

endmodule
`default_nettype wire
